### rtl/frlp_pkg.sv
package frlp_pkg;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_CHAR  = 2'd0,
    REQ_END   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  // sticky status codes
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_INT   = 2'd1,
    ERR_SEP   = 2'd2,
    ERR_RANGE = 2'd3
  } err_e;

  // parser phase
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_FWD   = 3'd1,
    PH_INT   = 3'd2,
    PH_RANGE = 3'd3,
    PH_ERROR = 3'd4
  } phase_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_MRD  = 5'b00100,
    ST_MWR  = 5'b01000,
    ST_QRD  = 5'b10000
  } state_e;

  // list characters
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // bitmap word geometry
  localparam int WORD_W  = 32;
  localparam int WORD_OW = 5;

  // window of one bitmap word that a range fill touches
  typedef struct packed {
    logic               first;
    logic               last;
    logic [WORD_OW-1:0] lo_off;
    logic [WORD_OW-1:0] hi_off;
  } mark_win_t;

endpackage

### rtl/frlp_ram.sv
module frlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/frlp_mark_unit.sv
module frlp_mark_unit (
  input  logic [frlp_pkg::WORD_W-1:0] old_word_i,
  input  frlp_pkg::mark_win_t         win_i,
  output logic [frlp_pkg::WORD_W-1:0] new_word_o,
  output logic [frlp_pkg::WORD_OW:0]  add_cnt_o
);
  import frlp_pkg::*;

  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  fresh;
  logic [WORD_OW-1:0] hi_shift;

  // bits of this word that lie inside the range
  assign hi_shift = WORD_OW'(WORD_W - 1) - win_i.hi_off;
  assign lo_mask  = win_i.first ? ({WORD_W{1'b1}} << win_i.lo_off) : {WORD_W{1'b1}};
  assign hi_mask  = win_i.last ? ({WORD_W{1'b1}} >> hi_shift) : {WORD_W{1'b1}};
  assign mask     = lo_mask & hi_mask;

  // set the bits and count the ones not set before
  assign fresh      = mask & ~old_word_i;
  assign new_word_o = old_word_i | mask;
  assign add_cnt_o  = (WORD_OW + 1)'($countones(fresh));

endmodule

### rtl/field_range_list_parser_core.sv
// Field list parser: takes a cut-style list (1,3-5,7- or -4) one character
// per item and keeps a bitmap of the selected fields.
// Input channel s_axis: tuser is the request kind (character, end of string,
// query, clear), tdata carries the character and the queried field number.
// Output channel m_axis: exactly one result item per input item, holding the
// sticky status, the query answer and the count of marked fields.
// Timing: a character or end of string that marks nothing, and a query
// answered by the up-to or from selections or out of range, finish in the
// accept cycle. A query of the bitmap waits for one memory read. A number
// that marks fields walks the bitmap one 32-bit word at a time through the
// read-modify-write unit, a read state and a write state per word. A clear
// request answers after the clearing sweep. After reset the bitmap is swept
// clear; no item is accepted meanwhile.
// s_axis_tready_o is high only while the sequencer is idle and the output
// register is empty or being read; a stalled receiver holds the result and
// blocks the next item.
module field_range_list_parser_core #(
  parameter int MAX_FIELDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_byte, [18:8] field_number, [23:19] zero
  input  logic [23:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [2] is_selected, [13:3] fields_selected, [15:14] zero
  output logic [15:0] m_axis_tdata_o
);
  import frlp_pkg::*;

  localparam int NW    = $clog2(MAX_FIELDS + 2);
  localparam int DEPTH = (MAX_FIELDS + WORD_W - 1) / WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (NW > 11) ? NW : 11;
  localparam int XW    = (CW > AW + WORD_OW) ? CW : AW + WORD_OW;
  localparam logic [NW+3:0] MAXW = (NW + 4)'(MAX_FIELDS);
  localparam logic [NW-1:0] MAXN = NW'(MAX_FIELDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

  // input fields
  logic [1:0]  in_req;
  logic [7:0]  in_char;
  logic [10:0] in_num;
  logic        s_fire;

  assign in_req  = s_axis_tuser_i;
  assign in_char = s_axis_tdata_i[7:0];
  assign in_num  = s_axis_tdata_i[18:8];

  // control and parser state
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  err_e            err_q, err_d;
  logic [NW-1:0]   acc_q, acc_d;
  logic            seen_q, seen_d;
  logic [NW-1:0]   rbeg_q, rbeg_d;
  logic [NW-1:0]   upto_q, upto_d;
  logic            upto_vld_q, upto_vld_d;
  logic [NW-1:0]   from_q, from_d;
  logic            from_vld_q, from_vld_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   word_q, word_d;
  logic [NW-1:0]   lo0_q, lo0_d;
  logic [NW-1:0]   hi0_q, hi0_d;
  logic [WORD_OW-1:0] qbit_q, qbit_d;
  logic            clr_reply_q, clr_reply_d;

  // output register
  logic            out_vld_q;
  logic [1:0]      out_status_q;
  logic            out_sel_q;
  logic [10:0]     out_cnt_q;
  logic            out_load;
  logic [1:0]      out_status_n;
  logic            out_sel_n;
  logic [NW-1:0]   out_cnt_n;
  logic [CW-1:0]   out_cnt_ext;

  // memory and shared unit
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  mark_win_t          win;
  logic [WORD_W-1:0]  unit_word;
  logic [WORD_OW:0]   unit_cnt;

  // word windows of the current fill
  logic [XW-1:0] lo0_ext, hi0_ext;
  logic [AW-1:0] hi_word;

  // query address
  logic [XW-1:0] qidx_ext;
  logic [AW-1:0] qword;

  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE) & (~out_vld_q | m_axis_tready_i);

  assign lo0_ext  = XW'(lo0_q);
  assign hi0_ext  = XW'(hi0_q);
  assign hi_word  = hi0_ext[AW+WORD_OW-1:WORD_OW];
  assign qidx_ext = XW'(in_num) - XW'(1);
  assign qword    = qidx_ext[AW+WORD_OW-1:WORD_OW];

  assign win.first  = (word_q == lo0_ext[AW+WORD_OW-1:WORD_OW]);
  assign win.last   = (word_q == hi_word);
  assign win.lo_off = lo0_q[WORD_OW-1:0];
  assign win.hi_off = hi0_q[WORD_OW-1:0];

  frlp_mark_unit u_mark (
    .old_word_i (ram_rdata),
    .win_i      (win),
    .new_word_o (unit_word),
    .add_cnt_o  (unit_cnt)
  );

  frlp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // word index of a zero-based field index
  function automatic logic [AW-1:0] lo0_word(input logic [NW-1:0] idx);
    logic [XW-1:0] ext;
    ext = XW'(idx);
    return ext[AW+WORD_OW-1:WORD_OW];
  endfunction

  // sequencer and parser next state
  always_comb begin
    logic [NW+3:0] prod;
    logic [NW-1:0] fin_v;
    logic          mark_go;
    logic [NW-1:0] mark_lo;
    logic [NW-1:0] mark_hi;
    logic          fin_ok;
    logic          qread;
    logic [CW-1:0] n_ext;

    state_d     = state_q;
    phase_d     = phase_q;
    err_d       = err_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    rbeg_d      = rbeg_q;
    upto_d      = upto_q;
    upto_vld_d  = upto_vld_q;
    from_d      = from_q;
    from_vld_d  = from_vld_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    lo0_d       = lo0_q;
    hi0_d       = hi0_q;
    qbit_d      = qbit_q;
    clr_reply_d = clr_reply_q;

    out_load     = 1'b0;
    out_status_n = err_q;
    out_sel_n    = 1'b0;
    out_cnt_n    = cnt_q;

    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = unit_word;
    ram_raddr = (state_q == ST_IDLE) ? qword : word_q;

    prod    = (NW + 4)'({acc_q, 3'b000}) + (NW + 4)'({acc_q, 1'b0})
            + (NW + 4)'(in_char[3:0] - CHAR_ZERO[3:0]);
    fin_v   = acc_q;
    fin_ok  = (fin_v != '0) && (fin_v <= MAXN);
    mark_go = 1'b0;
    mark_lo = fin_v;
    mark_hi = fin_v;
    qread   = 1'b0;
    n_ext   = CW'(in_num);

    case (state_q)
      // clearing sweep after reset or a clear request
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        word_d    = word_q + AW'(1);
        if (word_q == LAST_WORD) begin
          state_d     = ST_IDLE;
          word_d      = '0;
          clr_reply_d = 1'b0;
          if (clr_reply_q) begin
            out_load     = 1'b1;
            out_status_n = ERR_NONE;
            out_cnt_n    = '0;
          end
        end
      end

      // take one item
      ST_IDLE: begin
        if (s_fire) begin
          case (in_req)
            REQ_CHAR: begin
              if (phase_q != PH_ERROR) begin
                if (in_char inside {[CHAR_ZERO:CHAR_NINE]}) begin
                  if (phase_q == PH_START) begin
                    phase_d = PH_INT;
                  end
                  acc_d  = (prod > MAXW) ? MAXN + NW'(1) : NW'(prod);
                  seen_d = 1'b1;
                end else if (phase_q == PH_START) begin
                  if (in_char == CHAR_DASH) begin
                    rbeg_d  = NW'(1);
                    phase_d = PH_FWD;
                  end else begin
                    err_d   = ERR_INT;
                    phase_d = PH_ERROR;
                  end
                end else if (!seen_q) begin
                  err_d   = ERR_INT;
                  phase_d = PH_ERROR;
                end else begin
                  acc_d  = '0;
                  seen_d = 1'b0;
                  if (!fin_ok) begin
                    err_d   = ERR_RANGE;
                    phase_d = PH_ERROR;
                  end else begin
                    mark_go = 1'b1;
                    if (phase_q == PH_FWD) begin
                      mark_lo    = NW'(1);
                      upto_d     = fin_v;
                      upto_vld_d = 1'b1;
                    end else if (phase_q == PH_RANGE) begin
                      mark_lo = rbeg_q;
                    end
                    if (in_char == CHAR_DASH) begin
                      rbeg_d  = fin_v;
                      phase_d = PH_RANGE;
                    end else if (in_char == CHAR_COMMA) begin
                      phase_d = PH_INT;
                    end else begin
                      err_d   = ERR_SEP;
                      phase_d = PH_ERROR;
                    end
                  end
                end
              end
            end
            REQ_END: begin
              if (phase_q != PH_ERROR) begin
                acc_d  = '0;
                seen_d = 1'b0;
                if (seen_q && !fin_ok) begin
                  err_d   = ERR_RANGE;
                  phase_d = PH_ERROR;
                end else begin
                  phase_d = PH_START;
                  if (seen_q) begin
                    mark_go = 1'b1;
                    if (phase_q == PH_FWD) begin
                      mark_lo    = NW'(1);
                      upto_d     = fin_v;
                      upto_vld_d = 1'b1;
                    end else if (phase_q == PH_RANGE) begin
                      mark_lo = rbeg_q;
                    end
                  end else if (phase_q == PH_FWD || phase_q == PH_RANGE) begin
                    from_d     = (phase_q == PH_FWD) ? NW'(1) : rbeg_q;
                    from_vld_d = 1'b1;
                  end
                end
              end
            end
            REQ_QUERY: begin
              if (in_num == '0) begin
                out_sel_n = 1'b0;
              end else if (upto_vld_q && n_ext <= CW'(upto_q)) begin
                out_sel_n = 1'b1;
              end else if (from_vld_q && n_ext >= CW'(from_q)) begin
                out_sel_n = 1'b1;
              end else if (n_ext > CW'(MAX_FIELDS)) begin
                out_sel_n = 1'b0;
              end else begin
                qread  = 1'b1;
                qbit_d = qidx_ext[WORD_OW-1:0];
              end
            end
            default: begin
              // clear: back to reset state, then sweep the bitmap
              phase_d     = PH_START;
              err_d       = ERR_NONE;
              acc_d       = '0;
              seen_d      = 1'b0;
              rbeg_d      = '0;
              upto_d      = '0;
              upto_vld_d  = 1'b0;
              from_d      = '0;
              from_vld_d  = 1'b0;
              cnt_d       = '0;
              word_d      = '0;
              clr_reply_d = 1'b1;
              state_d     = ST_CLR;
            end
          endcase

          // start a fill, a bitmap read, or answer now
          if (in_req != REQ_CLEAR) begin
            if (mark_go && (mark_hi >= mark_lo)) begin
              lo0_d   = mark_lo - NW'(1);
              hi0_d   = mark_hi - NW'(1);
              state_d = ST_MRD;
            end else if (qread) begin
              state_d = ST_QRD;
            end else begin
              out_load     = 1'b1;
              out_status_n = err_d;
            end
          end
        end
      end

      // read the next bitmap word of the fill
      ST_MRD: begin
        state_d = ST_MWR;
      end

      // merge the range into the word and count new fields
      ST_MWR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + NW'(unit_cnt);
        if (win.last) begin
          state_d   = ST_IDLE;
          out_load  = 1'b1;
          out_cnt_n = cnt_d;
        end else begin
          word_d  = word_q + AW'(1);
          state_d = ST_MRD;
        end
      end

      // bitmap word of a query is back
      ST_QRD: begin
        state_d   = ST_IDLE;
        out_load  = 1'b1;
        out_sel_n = ram_rdata[qbit_q];
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // first word of a fill comes from the lower bound
    if (state_q == ST_IDLE && state_d == ST_MRD) begin
      word_d = lo0_word(lo0_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      phase_q     <= PH_START;
      err_q       <= ERR_NONE;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      rbeg_q      <= '0;
      upto_q      <= '0;
      upto_vld_q  <= 1'b0;
      from_q      <= '0;
      from_vld_q  <= 1'b0;
      cnt_q       <= '0;
      word_q      <= '0;
      clr_reply_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      err_q       <= err_d;
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      rbeg_q      <= rbeg_d;
      upto_q      <= upto_d;
      upto_vld_q  <= upto_vld_d;
      from_q      <= from_d;
      from_vld_q  <= from_vld_d;
      cnt_q       <= cnt_d;
      word_q      <= word_d;
      clr_reply_q <= clr_reply_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  assign out_cnt_ext = CW'(out_cnt_n);

  always_ff @(posedge clk_i) begin
    lo0_q  <= lo0_d;
    hi0_q  <= hi0_d;
    qbit_q <= qbit_d;
    if (out_load) begin
      out_status_q <= out_status_n;
      out_sel_q    <= out_sel_n;
      out_cnt_q    <= out_cnt_ext[10:0];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_cnt_q, out_sel_q, out_status_q};

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import frlp_pkg::*;

  localparam int MAX_F = 1024;
  localparam int RANDOM_ITEMS = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // [7:0] char_byte, [18:8] field_number, [23:19] zero
  logic [23:0] s_axis_tdata_i;
  // [1:0] req_type
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // [1:0] status, [2] is_selected, [13:3] fields_selected, [15:14] zero
  logic [15:0] m_axis_tdata_o;

  typedef struct packed {
    err_e        status;
    logic        is_sel;
    logic [10:0] sel_count;
  } parse_result_t;

  field_range_list_parser_core #(
    .MAX_FIELDS(MAX_F)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // parser mirror state
  phase_e cur_phase;
  int     num_acc;
  bit     have_digit;
  int     range_lo;
  int     upto_lim;
  bit     upto_on;
  int     from_lim;
  bit     from_on;
  logic   sel_map [1:MAX_F];
  int     top_marked;
  int     sel_total;
  err_e   sticky_err;

  parse_result_t expected_results[$];
  int fail_count;
  int useful_items;
  int burst_left;
  int result_idx;

  function automatic void clear_parser();
    cur_phase  = PH_START;
    num_acc    = 0;
    have_digit = 1'b0;
    range_lo   = 0;
    upto_lim   = 0;
    upto_on    = 1'b0;
    from_lim   = 0;
    from_on    = 1'b0;
    for (int i = 1; i <= MAX_F; i++) sel_map[i] = 1'b0;
    top_marked = 0;
    sel_total  = 0;
    sticky_err = ERR_NONE;
  endfunction

  function automatic void flag_error(err_e code);
    sticky_err = code;
    cur_phase  = PH_ERROR;
  endfunction

  // mark lo..hi, both already within 1..MAX_F
  function automatic void mark_range(int lo, int hi);
    if (hi > top_marked) top_marked = hi;
    for (int i = lo; i <= hi; i++) begin
      if (!sel_map[i]) begin
        sel_map[i] = 1'b1;
        sel_total++;
      end
    end
  endfunction

  // complete the pending number, zero on a range error
  function automatic bit close_number(output int val);
    val        = num_acc;
    num_acc    = 0;
    have_digit = 1'b0;
    if (val == 0 || val > MAX_F) begin
      flag_error(ERR_RANGE);
      return 1'b0;
    end
    case (cur_phase)
      PH_FWD: begin
        mark_range(1, val);
        upto_lim = val;
        upto_on  = 1'b1;
      end
      PH_RANGE: mark_range(range_lo, val);
      default:  mark_range(val, val);
    endcase
    return 1'b1;
  endfunction

  function automatic void take_list_char(logic [7:0] c);
    int v;
    if (cur_phase == PH_ERROR) return;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (cur_phase == PH_START) cur_phase = PH_INT;
      num_acc = num_acc * 10 + int'(c - CHAR_ZERO);
      if (num_acc > MAX_F) num_acc = MAX_F + 1;
      have_digit = 1'b1;
      return;
    end
    if (cur_phase == PH_START) begin
      if (c == CHAR_DASH) begin
        range_lo  = 1;
        cur_phase = PH_FWD;
      end else begin
        flag_error(ERR_INT);
      end
      return;
    end
    if (!have_digit) begin
      flag_error(ERR_INT);
      return;
    end
    if (!close_number(v)) return;
    if (c == CHAR_DASH) begin
      range_lo  = v;
      cur_phase = PH_RANGE;
    end else if (c == CHAR_COMMA) begin
      cur_phase = PH_INT;
    end else begin
      flag_error(ERR_SEP);
    end
  endfunction

  function automatic void take_list_end();
    int v;
    if (cur_phase == PH_ERROR) return;
    if (have_digit) begin
      if (!close_number(v)) return;
    end else if (cur_phase == PH_FWD || cur_phase == PH_RANGE) begin
      from_lim = (cur_phase == PH_FWD) ? 1 : range_lo;
      from_on  = 1'b1;
    end
    cur_phase  = PH_START;
    num_acc    = 0;
    have_digit = 1'b0;
  endfunction

  function automatic logic field_is_selected(int n);
    if (n == 0) return 1'b0;
    if (upto_on && n <= upto_lim) return 1'b1;
    if (from_on && n >= from_lim) return 1'b1;
    if (n > top_marked || n > MAX_F) return 1'b0;
    return sel_map[n];
  endfunction

  function automatic parse_result_t predict_parse_result(req_e req, logic [7:0] ch,
                                                          logic [10:0] num);
    parse_result_t r;
    r.is_sel = 1'b0;
    case (req)
      REQ_CHAR:  take_list_char(ch);
      REQ_END:   take_list_end();
      REQ_QUERY: r.is_sel = field_is_selected(int'(num));
      default:   clear_parser();
    endcase
    r.status    = sticky_err;
    r.sel_count = sel_total[10:0];
    return r;
  endfunction

  task automatic report_fail(string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  // send one item, bursts of random length separated by random gaps
  task automatic send_item(req_e req, logic [7:0] ch, logic [10:0] num);
    int  gap;
    bit  ignored;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {5'b0, num, ch};
    do @(posedge clk_i); while (!s_axis_tready_o);
    ignored = (req == REQ_CHAR || req == REQ_END) && cur_phase == PH_ERROR;
    expected_results.push_back(predict_parse_result(req, ch, num));
    if (!ignored) useful_items++;
    burst_left--;
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(REQ_CHAR, c, 11'($urandom));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_end();
    send_item(REQ_END, 8'($urandom), 11'($urandom));
  endtask

  task automatic send_query(logic [10:0] n);
    send_item(REQ_QUERY, 8'($urandom), n);
  endtask

  task automatic send_clear();
    send_item(REQ_CLEAR, 8'($urandom), 11'($urandom));
  endtask

  // decimal text of a field number, mostly small
  function automatic string field_text();
    int    v;
    int    r;
    string s;
    r = $urandom_range(0, 29);
    if (r == 0)      v = 0;
    else if (r == 1) v = MAX_F + 1;
    else if (r == 2) v = 99999;
    else if (r == 3) v = MAX_F;
    else if (r < 7)  v = $urandom_range(1, MAX_F);
    else             v = $urandom_range(1, 40);
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic logic [10:0] query_number();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 11'($urandom);
    if (r == 2) return 11'($urandom_range(MAX_F - 2, MAX_F + 2));
    return 11'($urandom_range(0, 48));
  endfunction

  // one well-formed list with random content, sometimes broken
  task automatic send_random_list();
    string s;
    int    n_elem;
    int    noise_at;
    s = "";
    n_elem = $urandom_range(1, 4);
    if ($urandom_range(0, 5) == 0) s = {"-", field_text()};
    repeat (n_elem) begin
      if (s.len() > 0) s = {s, ","};
      s = {s, field_text()};
      if ($urandom_range(0, 2) == 0) s = {s, "-", field_text()};
    end
    case ($urandom_range(0, 11))
      0: s = {s, ","};
      1: s = {s, ",", field_text(), "-"};
      2: s = "-";
      3: s = {s, "-"};
      default: ;
    endcase
    noise_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, s.len()) : -1;
    for (int i = 0; i <= s.len(); i++) begin
      if (i == noise_at) send_char(8'($urandom));
      if (i < s.len()) send_char(s[i]);
    end
    if ($urandom_range(0, 19) != 0) send_end();
  endtask

  // reversed range, open range, trailing comma, empty list
  task automatic test_list_forms();
    send_end();
    send_text("3-1,");
    send_end();
    send_text("2-");
    send_end();
    send_query(11'd0);
    send_query(11'h7FF);
  endtask

  // leading up-to range over the whole bitmap
  task automatic test_upto_full();
    send_clear();
    send_text("-1024");
    send_end();
    send_query(11'(MAX_F));
  endtask

  // sticky errors and what follows them
  task automatic test_error_cases();
    send_clear();
    send_text("7");
    send_char(8'h00);
    send_char("9");
    send_end();
    send_clear();
    send_char(8'hFF);
    send_clear();
    send_text("0,");
  endtask

  task automatic test_random_traffic();
    int r;
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 12)      send_random_list();
      else if (r < 16) repeat ($urandom_range(1, 3)) send_query(query_number());
      else if (r < 17) send_clear();
      else if (r < 19) send_item(req_e'($urandom_range(0, 3)), 8'($urandom), 11'($urandom));
      else             send_end();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : check_result
    parse_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_fail($sformatf("result %0d with no item pending, tdata %h",
                              result_idx, m_axis_tdata_o));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[1:0] != want.status)
          report_fail($sformatf("result %0d status got %0d expected %0d",
                                result_idx, m_axis_tdata_o[1:0], want.status));
        if (m_axis_tdata_o[2] != want.is_sel)
          report_fail($sformatf("result %0d is_selected got %0d expected %0d",
                                result_idx, m_axis_tdata_o[2], want.is_sel));
        if (m_axis_tdata_o[13:3] != want.sel_count)
          report_fail($sformatf("result %0d fields_selected got %0d expected %0d",
                                result_idx, m_axis_tdata_o[13:3], want.sel_count));
        if (m_axis_tdata_o[15:14] != 2'b00)
          report_fail($sformatf("result %0d padding bits not zero", result_idx));
      end
      result_idx++;
    end
  end

  // receiver stall pattern
  initial begin : result_sink
    int mode;
    int left;
    int run;
    bit hold;
    m_axis_tready_i <= 1'b0;
    mode = 0;
    left = 0;
    run  = 0;
    hold = 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ~m_axis_tready_i;
        2: m_axis_tready_i <= 1'($urandom_range(0, 1));
        default: begin
          if (run == 0) begin
            hold = !hold;
            run  = hold ? $urandom_range(1, 15) : $urandom_range(1, 6);
          end
          run--;
          m_axis_tready_i <= !hold;
        end
      endcase
    end
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fail_count = 0;
    useful_items = 0;
    burst_left = 0;
    result_idx = 0;
    clear_parser();
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= REQ_CHAR;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_list_forms();
    test_upto_full();
    test_error_cases();
    test_random_traffic();

    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
